[rtl/core/svpm_pkg.sv]
package svpm_pkg;

    localparam int WindowLen   = 512;
    localparam int SampleBits  = 16;
    localparam int AddrBits    = $clog2(WindowLen);
    localparam int WinShift    = $clog2(WindowLen + 1) - 1;
    localparam int SqBits      = 2 * SampleBits;
    localparam int SumBits     = SqBits + AddrBits + 1;
    localparam int RootBits    = (SumBits + 1) / 2;
    localparam int RootSteps   = RootBits;

    localparam logic [15:0] ResetAttack  = 16'd7864;
    localparam logic [15:0] ResetRelease = 16'd63898;
    localparam logic [15:0] ResetDecay   = 16'd64881;
    localparam logic [15:0] ResetHold    = 16'd120;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_RELEASE = 2'd1,
        REG_DECAY   = 2'd2,
        REG_HOLD    = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_ROOT,
        ST_BALL,
        ST_OUT
    } state_t;

    // lane control from sequencer
    typedef struct packed {
        logic start;
        logic acc;
        logic root_start;
        logic ball;
    } lane_ctl_t;

    typedef struct packed {
        logic [15:0] attack;
        logic [15:0] release_c;
        logic [15:0] decay;
        logic [15:0] hold;
    } coefs_t;

endpackage

[rtl/core/svpm_ram.sv]
module svpm_ram #(
    parameter int Width = 16,
    parameter int Depth = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/core/svpm_lane.sv]
module svpm_lane (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  svpm_pkg::lane_ctl_t           ctl,
    input  svpm_pkg::coefs_t              coefs,
    input  logic [svpm_pkg::SampleBits-1:0] sample,
    output logic                          root_done,
    output logic [15:0]                   vu,
    output logic [15:0]                   peak
);
    import svpm_pkg::*;

    logic signed [SampleBits-1:0] s_reg;
    logic                         sv_reg;
    logic [SqBits-1:0]            sq_reg;
    logic [SampleBits-1:0]        ab_reg;
    logic                         pv_reg;
    logic [SumBits-1:0]           sum_reg;
    logic [SampleBits-1:0]        pk_reg;
    logic [SumBits-1:0]           rem_reg;
    logic [RootBits-1:0]          root_reg;
    logic [$clog2(RootSteps+1)-1:0] cnt_reg;
    logic                         busy_reg;
    logic [15:0]                  vu_reg, peak_reg, hold_reg;
    logic [31:0]                  m1_reg, m2_reg, m3_reg;
    logic [15:0]                  rms16, pk16;

    // square / magnitude pipeline, accumulate
    always_ff @(posedge aclk) begin
        s_reg  <= sample;
        sq_reg <= SqBits'(SqBits'(s_reg) * SqBits'(s_reg));
        ab_reg <= s_reg[SampleBits-1] ? SampleBits'(-s_reg) : SampleBits'(s_reg);
        if (!aresetn) begin
            sv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end else begin
            sv_reg <= ctl.acc;
            pv_reg <= sv_reg;
        end
        if (ctl.start) begin
            sum_reg <= '0;
            pk_reg  <= '0;
        end else if (pv_reg) begin
            sum_reg <= sum_reg + SumBits'(sq_reg);
            if (ab_reg > pk_reg) pk_reg <= ab_reg;
        end
    end

    // bit-per-cycle restoring square root
    logic [SumBits-1:0]   rad;
    logic [RootBits+1:0]  trial;
    logic [SumBits+1:0]   rem_sh;
    always_comb begin
        rad    = sum_reg >> WinShift;
        rem_sh = {rem_reg, 2'b00};
        trial  = {root_reg, 2'b01};
        rem_sh[1:0] = 2'(rad >> (2 * (RootSteps - 1 - int'(cnt_reg))));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (ctl.root_start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            if (rem_sh >= (SumBits+2)'(trial)) begin
                rem_reg  <= SumBits'(rem_sh - (SumBits+2)'(trial));
                root_reg <= {root_reg[RootBits-2:0], 1'b1};
            end else begin
                rem_reg  <= SumBits'(rem_sh);
                root_reg <= {root_reg[RootBits-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (32'(cnt_reg) == RootSteps - 1) busy_reg <= 1'b0;
        end
    end
    assign root_done = !busy_reg;

    assign rms16 = (root_reg > RootBits'(16'hFFFF)) ? 16'hFFFF : 16'(root_reg);
    assign pk16  = 16'(pk_reg);

    // products registered ahead of the ballistics update
    always_ff @(posedge aclk) begin
        m1_reg <= 32'(vu_reg) * 32'(17'h10000 - 17'(coefs.attack))
                + 32'(rms16) * 32'(coefs.attack);
        m2_reg <= 32'(vu_reg) * 32'(coefs.release_c);
        m3_reg <= 32'(peak_reg) * 32'(coefs.decay);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vu_reg   <= '0;
            peak_reg <= '0;
            hold_reg <= '0;
        end else if (ctl.ball) begin
            vu_reg <= (rms16 > vu_reg) ? m1_reg[31:16] : m2_reg[31:16];
            if (pk16 >= peak_reg) begin
                peak_reg <= pk16;
                hold_reg <= coefs.hold;
            end else if (hold_reg != 16'd0) begin
                hold_reg <= hold_reg - 16'd1;
            end else begin
                peak_reg <= m3_reg[31:16];
            end
        end
    end

    assign vu   = vu_reg;
    assign peak = peak_reg;

    a_pk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |=> (pk_reg >= $past(ab_reg) || $past(ctl.start)))
        else $error("peak lost");
    a_root_len: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.root_start |=> busy_reg)
        else $error("root not started");
    a_hold_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.ball && pk16 < peak_reg && hold_reg != 0) |=> hold_reg == $past(hold_reg) - 16'd1)
        else $error("hold count");
endmodule

[rtl/core/stereo_vu_peak_meter_unit.sv]
// Sample request: accepted back to back while idle, no result.
// Frame tick: walks the 512-entry window, then a bit-serial square root,
// a ballistics update and an output state that waits while the previous
// result is still pending; then the next request is taken in idle.
// Reset is synchronous active low; afterwards a clearing pass over all WindowLen
// entries zeroes the window memories while s_tready stays low.
module stereo_vu_peak_meter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // sample_left[15:0], sample_right[31:16]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // vu_left, vu_right, peak_left, peak_right
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import svpm_pkg::*;

    state_t              state_reg, state_next;
    logic [AddrBits:0]   cnt_reg, cnt_next;
    logic [AddrBits-1:0] widx_reg;
    coefs_t              coefs_reg;
    logic [63:0]         out_reg;
    logic                ov_reg;
    lane_ctl_t           ctl;
    logic                wr_en;
    logic [AddrBits-1:0] waddr, raddr;
    logic [15:0]         wl, wr, rl, rr;
    logic                dl, dr;
    logic [15:0]         vul, vur, pkl, pkr;
    logic                s_acc;

    assign s_acc = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg <= '{ResetAttack, ResetRelease, ResetDecay, ResetHold};
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ATTACK:  coefs_reg.attack    <= cfg_wdata;
                REG_RELEASE: coefs_reg.release_c <= cfg_wdata;
                REG_DECAY:   coefs_reg.decay     <= cfg_wdata;
                REG_HOLD:    coefs_reg.hold      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        wr_en      = 1'b0;
        waddr      = widx_reg;
        wl         = s_tdata[15:0];
        wr         = s_tdata[31:16];
        raddr      = cnt_reg[AddrBits-1:0];
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                waddr = cnt_reg[AddrBits-1:0];
                wl    = '0;
                wr    = '0;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == WindowLen - 1) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_acc) begin
                    if (!s_tuser) begin
                        wr_en = 1'b1;
                    end else begin
                        ctl.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // memory read -> lane square -> accumulate
                ctl.acc  = 32'(cnt_reg) >= 1 && 32'(cnt_reg) <= WindowLen;
                cnt_next = cnt_reg + 1'b1;
                if (32'(cnt_reg) == WindowLen + 2) begin
                    state_next = ST_ROOT;
                    ctl.root_start = 1'b1;
                end
            end
            ST_ROOT: begin
                cnt_next = '0;
                if (dl && dr && cnt_reg == '0) state_next = ST_BALL;
                if (cnt_reg != '0) cnt_next = '0;
            end
            ST_BALL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0]) begin
                    ctl.ball   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait here while the previous result is still pending
                if (!ov_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            widx_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_BALL || state_next == ST_BALL
                          || state_reg == ST_CLEAR || state_reg == ST_WALK
                          || state_next == ST_WALK) ? cnt_next : '0;
            if (s_acc && !s_tuser) widx_reg <= widx_reg + 1'b1;
            if (state_reg == ST_OUT && state_next == ST_IDLE) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && state_next == ST_IDLE) out_reg <= {pkr, pkl, vur, vul};
    end

    svpm_ram #(.Width(16), .Depth(WindowLen)) u_ram_l (
        .aclk(aclk), .we(wr_en), .waddr(waddr), .wdata(wl), .raddr(raddr), .rdata(rl));
    svpm_ram #(.Width(16), .Depth(WindowLen)) u_ram_r (
        .aclk(aclk), .we(wr_en), .waddr(waddr), .wdata(wr), .raddr(raddr), .rdata(rr));

    svpm_lane u_lane_l (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .coefs(coefs_reg), .sample(rl),
        .root_done(dl), .vu(vul), .peak(pkl));
    svpm_lane u_lane_r (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .coefs(coefs_reg), .sample(rr),
        .root_done(dr), .vu(vur), .peak(pkr));

    assign m_tvalid = ov_reg;
    assign m_tdata  = out_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_tready) |=> ov_reg && $stable(out_reg))
        else $error("result dropped");
    a_out_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |=> m_tvalid)
        else $error("result missing");
endmodule
